// ----- src/drs_pkg.sv -----
// Shared constants and types of the disk request scheduler.
package drs_pkg;

    localparam int MAX_REQUESTS_DEF  = 64;
    localparam int CYLINDER_BITS_DEF = 16;

    localparam int                SEEK_BITS = 23;
    localparam logic [SEEK_BITS-1:0] SEEK_MAX = 23'h7F_FFFF;
    localparam int                DCHG_BITS = 7;

    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_POLICY    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_CYL = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_DIR = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_CYL   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_CYL   = 3'd4;

    localparam int MODE_BITS = 3;
    localparam logic [MODE_BITS-1:0] MODE_FCFS  = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_SSTF  = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_SCAN  = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_CSCAN = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_LOOK  = 3'd4;

    localparam int MAX_CYL_RESET = 199;

    typedef struct packed {
        logic clear;        // drop the current best before a new pass
        logic cand_valid;   // a store word is on the candidate inputs
        logic cand_served;  // that word has already been served
    } t_pick_ctrl;

endpackage

// ----- src/drs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module drs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/drs_pick.sv -----
// Candidate selector: keeps the best unserved request of one pass over the store.
module drs_pick
    import drs_pkg::*;
#(
    parameter int MAX_REQUESTS  = MAX_REQUESTS_DEF,
    parameter int CYLINDER_BITS = CYLINDER_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_pick_ctrl                      i_ctrl,
    input  logic [MODE_BITS-1:0]            i_mode,
    input  logic [CYLINDER_BITS-1:0]        i_start_cyl,
    input  logic                            i_start_dir,
    input  logic [CYLINDER_BITS-1:0]        i_head,
    input  logic [CYLINDER_BITS-1:0]        i_cand_v,
    input  logic [$clog2(MAX_REQUESTS)-1:0] i_cand_i,
    output logic [CYLINDER_BITS-1:0]        o_best_v,
    output logic [$clog2(MAX_REQUESTS)-1:0] o_best_i,
    output logic                            o_best_g
);

    localparam int AW = $clog2(MAX_REQUESTS);

    logic                     r_found;
    logic [CYLINDER_BITS-1:0] r_best_v;
    logic [CYLINDER_BITS-1:0] r_best_d;
    logic [AW-1:0]            r_best_i;
    logic                     r_best_g;

    logic                     cand_g;
    logic                     want_min;
    logic [CYLINDER_BITS-1:0] cand_d;
    logic                     is_sstf;
    logic                     is_sweep;
    logic                     better;

    always_comb begin
        is_sstf  = (i_mode == MODE_SSTF);
        is_sweep = (i_mode == MODE_SCAN) || (i_mode == MODE_CSCAN) || (i_mode == MODE_LOOK);
        // second group: the requests served after the turn
        cand_g   = i_start_dir ? (i_cand_v < i_start_cyl) : (i_cand_v >= i_start_cyl);
        if (cand_g) begin
            want_min = (i_mode == MODE_CSCAN) ? i_start_dir : !i_start_dir;
        end else begin
            want_min = i_start_dir;
        end
        cand_d = (i_head > i_cand_v) ? (i_head - i_cand_v) : (i_cand_v - i_head);
        if (!r_found) begin
            better = 1'b1;
        end else if (is_sstf) begin
            better = (cand_d < r_best_d);
        end else if (is_sweep) begin
            if (cand_g != r_best_g) begin
                better = !cand_g;
            end else begin
                better = want_min ? (i_cand_v < r_best_v) : (i_cand_v > r_best_v);
            end
        end else begin
            better = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_found <= 1'b0;
        end else if (i_ctrl.cand_valid && !i_ctrl.cand_served && better) begin
            r_found <= 1'b1;
        end
        if (i_ctrl.cand_valid && !i_ctrl.cand_served && better && !i_ctrl.clear) begin
            r_best_v <= i_cand_v;
            r_best_d <= cand_d;
            r_best_i <= i_cand_i;
            r_best_g <= cand_g;
        end
    end

    assign o_best_v = r_best_v;
    assign o_best_i = r_best_i;
    assign o_best_g = r_best_g;

endmodule

// ----- src/disk_request_scheduler_unit.sv -----
// Top level of the disk request scheduler: store, control sequencer and result register.
//
//  channel   direction  handshake                        payload
//  request   in         i_req_valid / o_req_stall        i_request_cylinder, i_last_request
//  result    out        o_res_valid / i_res_stall        o_served_cylinder, o_total_seek,
//                                                        o_direction_changes, o_last_served
//  config    in         i_cfg_we (no wait)               i_cfg_index, i_cfg_data
//
// Requests load one word per cycle into the store RAM. The word flagged last
// starts scheduling: each result then takes one pass over the n stored words
// through the single RAM read port, plus an edge move on the turn of SCAN and
// C-SCAN. The request side stalls for the whole batch. A result waits in the
// output register while the next pass runs. Reset is synchronous and clears
// the control state and config.
module disk_request_scheduler_unit
    import drs_pkg::*;
#(
    parameter int MAX_REQUESTS  = MAX_REQUESTS_DEF,
    parameter int CYLINDER_BITS = CYLINDER_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    output logic                       o_req_stall,
    input  logic [CYLINDER_BITS-1:0]   i_request_cylinder,
    input  logic                       i_last_request,
    output logic                       o_res_valid,
    input  logic                       i_res_stall,
    output logic [CYLINDER_BITS-1:0]   o_served_cylinder,
    output logic [SEEK_BITS-1:0]       o_total_seek,
    output logic [DCHG_BITS-1:0]       o_direction_changes,
    output logic                       o_last_served,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [CYLINDER_BITS-1:0]   i_cfg_data
);

    localparam int AW   = $clog2(MAX_REQUESTS);
    localparam int CW   = $clog2(MAX_REQUESTS + 1);
    localparam int SUMW = ((CYLINDER_BITS > SEEK_BITS) ? CYLINDER_BITS : SEEK_BITS) + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_PICK, S_EDGE1, S_EDGE2, S_SERVE
    } t_state;

    t_state r_state;

    // configuration
    logic [MODE_BITS-1:0]     r_mode;
    logic [CYLINDER_BITS-1:0] r_start_cyl;
    logic                     r_start_dir;
    logic [CYLINDER_BITS-1:0] r_min_cyl;
    logic [CYLINDER_BITS-1:0] r_max_cyl;

    // batch state
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_served_cnt;
    logic [MAX_REQUESTS-1:0]  r_flags;
    logic [CYLINDER_BITS-1:0] r_head;
    logic                     r_dir;
    logic                     r_turned;
    logic [SEEK_BITS-1:0]     r_seek;
    logic [DCHG_BITS-1:0]     r_rev;

    // scan pipeline
    logic [CW-1:0]            r_rd_idx;
    logic                     r_cmp_v;
    logic [AW-1:0]            r_cmp_i;

    // result register
    logic                     r_out_valid;
    logic [CYLINDER_BITS-1:0] r_out_cyl;
    logic [SEEK_BITS-1:0]     r_out_seek;
    logic [DCHG_BITS-1:0]     r_out_rev;
    logic                     r_out_last;

    logic                     req_accept;
    logic                     res_accept;
    logic                     out_load;
    logic                     ram_we;
    logic                     ram_re;
    logic [CYLINDER_BITS-1:0] ram_rdata;
    t_pick_ctrl               pick_ctrl;
    logic [CYLINDER_BITS-1:0] best_v;
    logic [AW-1:0]            best_i;
    logic                     best_g;
    logic                     is_sstf;
    logic                     is_sweep;
    logic                     scan_last;
    logic                     out_free;
    logic [CYLINDER_BITS-1:0] edge_cyl;
    logic [CYLINDER_BITS-1:0] dist_tgt;
    logic [CYLINDER_BITS-1:0] dist_val;
    logic [CYLINDER_BITS-1:0] span;
    logic [CYLINDER_BITS-1:0] addend;
    logic [SUMW-1:0]          seek_sum;
    logic [SEEK_BITS-1:0]     n_seek;

    assign o_req_stall = (r_state != S_IDLE);
    assign req_accept  = i_req_valid && !o_req_stall;
    assign res_accept  = r_out_valid && !i_res_stall;
    assign out_free    = !r_out_valid || !i_res_stall;
    assign out_load    = (r_state == S_SERVE) && out_free;

    assign ram_we = req_accept && (r_count < CW'(MAX_REQUESTS));
    assign ram_re = (r_state == S_SCAN) && (r_rd_idx < r_count);

    drs_ram #(
        .WIDTH (CYLINDER_BITS),
        .DEPTH (MAX_REQUESTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_request_cylinder),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        pick_ctrl.clear       = (r_state == S_PICK);
        pick_ctrl.cand_valid  = r_cmp_v;
        pick_ctrl.cand_served = r_flags[r_cmp_i];
    end

    drs_pick #(
        .MAX_REQUESTS  (MAX_REQUESTS),
        .CYLINDER_BITS (CYLINDER_BITS)
    ) u_pick (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (pick_ctrl),
        .i_mode      (r_mode),
        .i_start_cyl (r_start_cyl),
        .i_start_dir (r_start_dir),
        .i_head      (r_head),
        .i_cand_v    (ram_rdata),
        .i_cand_i    (r_cmp_i),
        .o_best_v    (best_v),
        .o_best_i    (best_i),
        .o_best_g    (best_g)
    );

    always_comb begin
        is_sstf   = (r_mode == MODE_SSTF);
        is_sweep  = (r_mode == MODE_SCAN) || (r_mode == MODE_CSCAN) || (r_mode == MODE_LOOK);
        scan_last = r_cmp_v && ((CW'(r_cmp_i) + CW'(1)) == r_count);
        edge_cyl  = r_start_dir ? r_max_cyl : r_min_cyl;
        dist_tgt  = (r_state == S_EDGE1) ? edge_cyl : best_v;
        dist_val  = (r_head > dist_tgt) ? (r_head - dist_tgt) : (dist_tgt - r_head);
        span      = (r_max_cyl > r_min_cyl) ? (r_max_cyl - r_min_cyl) : (r_min_cyl - r_max_cyl);
        addend    = (r_state == S_EDGE2) ? span : dist_val;
        seek_sum  = SUMW'(r_seek) + SUMW'(addend);
        // saturate the running travel
        n_seek    = (seek_sum > SUMW'(SEEK_MAX)) ? SEEK_MAX : seek_sum[SEEK_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= MODE_FCFS;
            r_start_cyl  <= '0;
            r_start_dir  <= 1'b1;
            r_min_cyl    <= '0;
            r_max_cyl    <= CYLINDER_BITS'(MAX_CYL_RESET);
            r_count      <= '0;
            r_served_cnt <= '0;
            r_flags      <= '0;
            r_head       <= '0;
            r_dir        <= 1'b0;
            r_turned     <= 1'b0;
            r_seek       <= '0;
            r_rev        <= '0;
            r_rd_idx     <= '0;
            r_cmp_v      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_POLICY:    r_mode      <= i_cfg_data[MODE_BITS-1:0];
                    CFG_START_CYL: r_start_cyl <= i_cfg_data;
                    CFG_START_DIR: r_start_dir <= i_cfg_data[0];
                    CFG_MIN_CYL:   r_min_cyl   <= i_cfg_data;
                    CFG_MAX_CYL:   r_max_cyl   <= i_cfg_data;
                    default: ;
                endcase
            end

            // a new word takes the output register as the old one leaves
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (res_accept) begin
                r_out_valid <= 1'b0;
            end

            r_cmp_v <= ram_re;
            r_cmp_i <= r_rd_idx[AW-1:0];

            case (r_state)
                S_IDLE: begin
                    if (ram_we) begin
                        r_count <= r_count + CW'(1);
                    end
                    if (req_accept && i_last_request) begin
                        // start the batch from the configured head
                        r_head       <= r_start_cyl;
                        r_dir        <= r_start_dir;
                        r_seek       <= '0;
                        r_rev        <= '0;
                        r_flags      <= '0;
                        r_turned     <= 1'b0;
                        r_served_cnt <= '0;
                        r_rd_idx     <= '0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (ram_re) begin
                        r_rd_idx <= r_rd_idx + CW'(1);
                    end
                    if (scan_last) begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (is_sweep) begin
                        if (best_g && !r_turned) begin
                            // turn or jump once, before the first word of the return group
                            r_turned <= 1'b1;
                            r_rev    <= r_rev + DCHG_BITS'(1);
                            r_state  <= (r_mode == MODE_LOOK) ? S_SERVE : S_EDGE1;
                        end else begin
                            r_state <= S_SERVE;
                        end
                    end else if (is_sstf) begin
                        if (r_dir && best_v < r_head) begin
                            r_dir <= 1'b0;
                            r_rev <= r_rev + DCHG_BITS'(1);
                        end else if (!r_dir && best_v > r_head) begin
                            r_dir <= 1'b1;
                            r_rev <= r_rev + DCHG_BITS'(1);
                        end
                        r_state <= S_SERVE;
                    end else begin
                        if ((best_v >= r_head) != r_dir) begin
                            r_dir <= !r_dir;
                            r_rev <= r_rev + DCHG_BITS'(1);
                        end
                        r_state <= S_SERVE;
                    end
                end
                S_EDGE1: begin
                    r_seek  <= n_seek;
                    r_head  <= edge_cyl;
                    r_state <= (r_mode == MODE_CSCAN) ? S_EDGE2 : S_SERVE;
                end
                S_EDGE2: begin
                    // circular jump lands on the opposite edge
                    r_seek  <= n_seek;
                    r_head  <= r_start_dir ? r_min_cyl : r_max_cyl;
                    r_state <= S_SERVE;
                end
                S_SERVE: begin
                    if (out_free) begin
                        r_seek          <= n_seek;
                        r_head          <= best_v;
                        r_flags[best_i] <= 1'b1;
                        r_served_cnt    <= r_served_cnt + CW'(1);
                        r_out_cyl       <= best_v;
                        r_out_seek      <= n_seek;
                        r_out_rev       <= r_rev;
                        r_out_last      <= ((r_served_cnt + CW'(1)) == r_count);
                        r_rd_idx        <= '0;
                        if ((r_served_cnt + CW'(1)) == r_count) begin
                            r_count <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res_valid         = r_out_valid;
    assign o_served_cylinder   = r_out_cyl;
    assign o_total_seek        = r_out_seek;
    assign o_direction_changes = r_out_rev;
    assign o_last_served       = r_out_last;

endmodule

// ----- verif/disk_request_scheduler_unit_test.sv -----
// Self-checking testbench of the disk request scheduler: random and directed batches.
//
// Batches of request words are queued by the stimulus block and fed to the block by a
// clocked driver at the falling edge. Each accepted word goes to a local copy of the
// scheduler, which works out the service order of a batch when its final word is
// taken and pushes the expected result words. A clocked monitor compares every
// accepted result word, field by field, with the oldest expectation.
module disk_request_scheduler_unit_test;
    import drs_pkg::*;

    localparam int  STORE_DEPTH = MAX_REQUESTS_DEF;
    localparam int  SETTLE      = 200;        // quiet cycles at the end of each drain
    localparam int  CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic [15:0] cyl;
        logic        last;
    } t_req_word;

    typedef struct packed {
        logic [15:0]          cyl;
        logic [SEEK_BITS-1:0] seek;
        logic [DCHG_BITS-1:0] turns;
        logic                 last;
    } t_svc_word;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_req_valid = 1'b0;
    logic                      o_req_stall;
    logic [15:0]               i_request_cylinder = '0;
    logic                      i_last_request = 1'b0;
    logic                      o_res_valid;
    logic                      i_res_stall = 1'b0;
    logic [15:0]               o_served_cylinder;
    logic [SEEK_BITS-1:0]      o_total_seek;
    logic [DCHG_BITS-1:0]      o_direction_changes;
    logic                      o_last_served;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [15:0]               i_cfg_data = '0;

    disk_request_scheduler_unit i_dut (.*);

    always #10 i_clk = ~i_clk;

    // Work still to do and results still owed
    t_req_word pending_q[$];
    t_svc_word due_q[$];

    // Shadow copy of the config registers, reset values
    logic [MODE_BITS-1:0] mode_sh  = MODE_FCFS;
    logic [15:0]          start_sh = '0;
    logic                 dir_sh   = 1'b1;
    logic [15:0]          min_sh   = '0;
    logic [15:0]          max_sh   = 16'(MAX_CYL_RESET);

    // Scheduler state of the local copy
    logic [15:0]          batch_cyl [STORE_DEPTH];
    int                   batch_n = 0;
    longint               head;
    logic                 head_up;
    longint               seek_run;
    logic [DCHG_BITS-1:0] turns;

    bit  failed = 1'b0;
    bit  calm = 1'b0;
    bit  taken = 1'b0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  total_items = 0;
    longint cycles = 0;

    function automatic longint span_of(longint a, longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Add travel to the running seek total, saturating at its top
    task automatic add_travel(input longint d);
        seek_run = seek_run + d;
        if (seek_run > longint'(SEEK_MAX)) seek_run = longint'(SEEK_MAX);
    endtask

    task automatic serve_cyl(input logic [15:0] c);
        t_svc_word w;
        add_travel(span_of(head, c));
        head = c;
        w.cyl   = c;
        w.seek  = seek_run[SEEK_BITS-1:0];
        w.turns = turns;
        w.last  = 1'b0;
        due_q.push_back(w);
    endtask

    task automatic run_fifo_order();
        for (int i = 0; i < batch_n; i++) begin
            if ((batch_cyl[i] >= head) != head_up) begin
                head_up = ~head_up;
                turns++;
            end
            serve_cyl(batch_cyl[i]);
        end
    endtask

    // Nearest first; ties go to the earliest loaded word
    task automatic run_nearest_first();
        bit     done [STORE_DEPTH];
        int     best;
        longint bd, d;
        foreach (done[i]) done[i] = 1'b0;
        for (int k = 0; k < batch_n; k++) begin
            best = -1;
            bd = 0;
            for (int i = 0; i < batch_n; i++) begin
                d = span_of(head, batch_cyl[i]);
                if (!done[i] && (best < 0 || d < bd)) begin
                    best = i;
                    bd = d;
                end
            end
            done[best] = 1'b1;
            if (head_up && batch_cyl[best] < head) begin
                head_up = 1'b0;
                turns++;
            end else if (!head_up && batch_cyl[best] > head) begin
                head_up = 1'b1;
                turns++;
            end
            serve_cyl(batch_cyl[best]);
        end
    endtask

    // SCAN, C-SCAN and LOOK over the sorted batch
    task automatic run_sweep(input logic [MODE_BITS-1:0] m);
        logic [15:0] s [STORE_DEPTH];
        logic [15:0] v;
        int          j, below;
        longint      span;
        span = span_of(max_sh, min_sh);
        below = 0;
        for (int i = 0; i < batch_n; i++) begin
            v = batch_cyl[i];
            j = i;
            while (j > 0 && s[j-1] > v) begin
                s[j] = s[j-1];
                j--;
            end
            s[j] = v;
            if (v < head) below++;
        end
        if (head_up) begin
            for (int i = below; i < batch_n; i++) serve_cyl(s[i]);
            if (below > 0) begin
                turns++;
                if (m == MODE_CSCAN) begin
                    add_travel(span_of(head, max_sh));
                    add_travel(span);
                    head = min_sh;
                    for (int i = 0; i < below; i++) serve_cyl(s[i]);
                end else begin
                    if (m == MODE_SCAN) begin
                        add_travel(span_of(head, max_sh));
                        head = max_sh;
                    end
                    head_up = 1'b0;
                    for (int i = below; i > 0; i--) serve_cyl(s[i-1]);
                end
            end
        end else begin
            for (int i = below; i > 0; i--) serve_cyl(s[i-1]);
            if (below < batch_n) begin
                turns++;
                if (m == MODE_CSCAN) begin
                    add_travel(span_of(head, min_sh));
                    add_travel(span);
                    head = max_sh;
                    for (int i = batch_n; i > below; i--) serve_cyl(s[i-1]);
                end else begin
                    if (m == MODE_SCAN) begin
                        add_travel(span_of(head, min_sh));
                        head = min_sh;
                    end
                    head_up = 1'b1;
                    for (int i = below; i < batch_n; i++) serve_cyl(s[i]);
                end
            end
        end
    endtask

    // Take one request word; the final word of a batch yields its service order
    task automatic take_request(input logic [15:0] c, input logic fin);
        int first;
        if (batch_n < STORE_DEPTH) begin
            batch_cyl[batch_n] = c;
            batch_n++;
        end
        if (fin) begin
            head = start_sh;
            head_up = dir_sh;
            seek_run = 0;
            turns = '0;
            first = due_q.size();
            if (mode_sh == MODE_SSTF) run_nearest_first();
            else if (mode_sh == MODE_SCAN || mode_sh == MODE_CSCAN || mode_sh == MODE_LOOK)
                run_sweep(mode_sh);
            else run_fifo_order();
            if (due_q.size() > first) due_q[due_q.size()-1].last = 1'b1;
            batch_n = 0;
        end
    endtask

    // Request side: accept and predict, then the monitor on the result side
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else if (i_rst_n) begin
            if (i_req_valid && !o_req_stall) begin
                taken = 1'b1;
                take_request(i_request_cylinder, i_last_request);
            end
            if (o_res_valid && !i_res_stall) begin
                if (due_q.size() == 0) begin
                    $error("result word with nothing expected: cyl %0d", o_served_cylinder);
                    failed = 1'b1;
                end else begin
                    if (o_served_cylinder !== due_q[0].cyl) begin
                        $error("served_cylinder: expected %0d, got %0d",
                               due_q[0].cyl, o_served_cylinder);
                        failed = 1'b1;
                    end
                    if (o_total_seek !== due_q[0].seek) begin
                        $error("total_seek: expected %0d, got %0d",
                               due_q[0].seek, o_total_seek);
                        failed = 1'b1;
                    end
                    if (o_direction_changes !== due_q[0].turns) begin
                        $error("direction_changes: expected %0d, got %0d",
                               due_q[0].turns, o_direction_changes);
                        failed = 1'b1;
                    end
                    if (o_last_served !== due_q[0].last) begin
                        $error("last_served: expected %0d, got %0d",
                               due_q[0].last, o_last_served);
                        failed = 1'b1;
                    end
                    void'(due_q.pop_front());
                end
            end
        end
    end

    // Driver: hold a word until taken, then wait out a gap and advance
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_req_valid && !taken) begin
                // hold the stalled word
            end else if (send_gap > 0) begin
                send_gap--;
                i_req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                i_request_cylinder <= pending_q[0].cyl;
                i_last_request     <= pending_q[0].last;
                i_req_valid        <= 1'b1;
                void'(pending_q.pop_front());
                send_gap = pick_gap();
            end else begin
                i_req_valid <= 1'b0;
            end
            taken = 1'b0;

            // Result side back-pressure
            if (stall_left > 0) begin
                stall_left--;
                i_res_stall <= 1'b1;
            end else begin
                i_res_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    // Wait until every word is sent and every result has come, then let the block settle
    task automatic drain();
        while (pending_q.size() > 0 || i_req_valid || due_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] d);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        case (idx)
            CFG_POLICY:    mode_sh  = d[MODE_BITS-1:0];
            CFG_START_CYL: start_sh = d;
            CFG_START_DIR: dir_sh   = d[0];
            CFG_MIN_CYL:   min_sh   = d;
            CFG_MAX_CYL:   max_sh   = d;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_all(input logic [MODE_BITS-1:0] m, input logic [15:0] st,
                           input logic up, input logic [15:0] lo, input logic [15:0] hi);
        write_reg(CFG_POLICY, 16'(m));
        write_reg(CFG_START_CYL, st);
        write_reg(CFG_START_DIR, 16'(up));
        write_reg(CFG_MIN_CYL, lo);
        write_reg(CFG_MAX_CYL, hi);
    endtask

    task automatic queue_word(input logic [15:0] c, input logic fin);
        t_req_word w;
        w.cyl = c;
        w.last = fin;
        pending_q.push_back(w);
        total_items++;
    endtask

    // Random batch: mostly cylinders near the start, some on the edges, some anywhere
    task automatic queue_batch(input int n, input int spread);
        int          r;
        logic [15:0] c;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 15) c = 16'($urandom);
            else if (r < 28) begin
                case ($urandom_range(0, 4))
                    0: c = 16'h0000;
                    1: c = 16'hFFFF;
                    2: c = min_sh;
                    3: c = max_sh;
                    default: c = start_sh;
                endcase
            end else c = 16'(int'(start_sh) + $urandom_range(0, 2 * spread) - spread);
            queue_word(c, k == n - 1);
        end
    endtask

    initial begin
        int n;
        int phase;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset config, first come first served across both extremes
        queue_word(16'd0, 1'b0);
        queue_word(16'hFFFF, 1'b0);
        queue_word(16'd199, 1'b0);
        queue_word(16'd0, 1'b1);
        drain();
        // Nearest first with a tie: 110 and 90 around 100, earliest wins
        set_all(MODE_SSTF, 16'd100, 1'b1, 16'd0, 16'd199);
        queue_word(16'd110, 1'b0);
        queue_word(16'd90, 1'b0);
        queue_word(16'd100, 1'b1);
        drain();
        // SCAN down: request on the start cylinder and on both edges
        set_all(MODE_SCAN, 16'd100, 1'b0, 16'd0, 16'd199);
        queue_word(16'd100, 1'b0);
        queue_word(16'd0, 1'b0);
        queue_word(16'd199, 1'b0);
        queue_word(16'd50, 1'b1);
        drain();
        // C-SCAN up with the jump across the span
        write_reg(CFG_POLICY, 16'(MODE_CSCAN));
        write_reg(CFG_START_DIR, 16'd1);
        queue_word(16'd20, 1'b0);
        queue_word(16'd180, 1'b0);
        queue_word(16'd5, 1'b1);
        drain();
        // LOOK with nothing behind the head: no turn; then a single-word batch
        write_reg(CFG_POLICY, 16'(MODE_LOOK));
        queue_word(16'd150, 1'b0);
        queue_word(16'd160, 1'b1);
        queue_word(16'd7, 1'b1);
        drain();
        // Unknown policy code and unknown register indexes; then min above max
        write_reg(CFG_POLICY, 16'd7);
        write_reg(3'd5, 16'hFFFF);
        write_reg(3'd6, 16'h1234);
        write_reg(3'd7, 16'h0000);
        queue_word(16'd300, 1'b0);
        queue_word(16'd40, 1'b1);
        drain();
        set_all(MODE_SCAN, 16'hFFFF, 1'b0, 16'd500, 16'd10);
        queue_word(16'd600, 1'b0);
        queue_word(16'd3, 1'b1);
        drain();

        // Random phases: a fresh config or one random register write and a new policy, a few batches, then drain
        phase = 0;
        while (total_items < 350) begin
            calm = ($urandom_range(0, 3) == 0);
            if (phase % 3 == 0) begin
                set_all(3'($urandom_range(0, 7)),
                        ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(0, 400)),
                        1'($urandom), 16'($urandom_range(0, 60)),
                        ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(100, 500)));
            end else begin
                write_reg(3'($urandom_range(0, 7)), 16'($urandom));
                write_reg(CFG_POLICY, 16'($urandom_range(0, 7)));
            end
            for (int b = 0; b < 3; b++) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
                if (phase == 4 && b == 0) n = 66;       // overfill: the tail is dropped
                if (phase == 9 && b == 0) n = STORE_DEPTH;
                queue_batch(n, $urandom_range(2, 120));
            end
            drain();
            phase++;
        end

        drain();
        if (!failed) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- disk_request_scheduler_unit.f -----
src/drs_pkg.sv
src/drs_ram.sv
src/drs_pick.sv
src/disk_request_scheduler_unit.sv
verif/disk_request_scheduler_unit_test.sv
